// File: design/lei_pkg.sv
// lorenz euler integrator package: fixed-point constants, reset values,
// sequencer codes and saturating arithmetic helpers
// no dependencies
`timescale 1ns / 1ps

package lei_pkg;

   localparam int FRAC_BITS = 24;
   localparam int DATA_W    = 32;
   localparam int OPND_W    = DATA_W + 1;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [63:0] BETA_RST_WIDE =
      ((64'd26666 << FRAC_BITS) + 64'd5000) / 64'd10000;

   localparam logic signed [DATA_W-1:0] SIGMA_RST = DATA_W'(64'd10 << FRAC_BITS);
   localparam logic signed [DATA_W-1:0] BETA_RST  = BETA_RST_WIDE[DATA_W-1:0];
   localparam logic signed [DATA_W-1:0] RHO_RST   = DATA_W'(64'd28 << FRAC_BITS);
   localparam logic [DATA_W-1:0]        DT_RST    = 32'd4294967;
   localparam logic signed [DATA_W-1:0] START_RST = DATA_W'(64'd1 << FRAC_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_DX,
      OP_DY,
      OP_XY,
      OP_DZ,
      OP_NX,
      OP_NY,
      OP_NZ,
      OP_END
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGMA,
      CSR_BETA,
      CSR_RHO,
      CSR_TIME_STEP,
      CSR_START_X,
      CSR_START_Y,
      CSR_START_Z
   } csr_idx_type;

   function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(Q_MAX);
      lo = PROD_W'(Q_MIN);
      if (v > hi) begin
         return Q_MAX;
      end else if (v < lo) begin
         return Q_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_narrow(input logic signed [OPND_W-1:0] v);
      if (v[OPND_W-1] != v[OPND_W-2]) begin
         return v[OPND_W-1] ? Q_MIN : Q_MAX;
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
      logic signed [OPND_W-1:0] d;
      d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      return sat_narrow(d);
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
      logic signed [OPND_W-1:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      return sat_narrow(s);
   endfunction

   // fixed-point product: floor shift by the fraction width, then saturate
   function automatic logic signed [DATA_W-1:0] mulq_post(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] sh;
      sh = p >>> FRAC_BITS;
      return sat_wide(sh);
   endfunction

endpackage

// File: design/lorenz_euler_integrator_unit.sv
// lorenz euler integrator top level: csr bank, step sequencer, shared
// multiplier with post stage, and result register; uses lei_pkg
`timescale 1ns / 1ps
//
//   channel   direction   handshake          payload
//   req       in          req_valid/stall    req_restart
//   rsp       out         rsp_valid/stall    rsp_point_x, rsp_point_y, rsp_point_z
//   csr       in          csr_valid/ready    csr_index, csr_wdata
//
// an euler step goes from accept through slots DX, DY, XY, DZ, NX, NY, NZ, END
// on the shared 33x33 multiplier and its post stage, then hands the point to
// the result register; a restart beat loads the start point and hands it on
// req_stall is high from accept until the point moves to the result register
// the result register holds a finished beat while the next one is accepted
// reset loads the default coefficients and start point 1.0, 1.0, 1.0

module lorenz_euler_integrator_unit
   import lei_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_restart,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_point_x,
   output logic signed [DATA_W-1:0] rsp_point_y,
   output logic signed [DATA_W-1:0] rsp_point_z,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in, post_op;

   logic signed [DATA_W-1:0] sigma_ff, beta_ff, rho_ff;
   logic        [DATA_W-1:0] dt_ff;
   logic signed [DATA_W-1:0] start_x_ff, start_y_ff, start_z_ff;

   logic signed [DATA_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic signed [DATA_W-1:0] diff_yx_ff, diff_yx_in, diff_rz_ff, diff_rz_in;
   logic signed [DATA_W-1:0] dx_ff, dx_in, dy_ff, dy_in, m3_ff, m3_in, dz_ff, dz_in;
   logic signed [OPND_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] prod_q;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;

   logic req_accept;
   logic csr_write;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_point_z = rsp_z_ff;

   // csr bank
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff   <= SIGMA_RST;
         beta_ff    <= BETA_RST;
         rho_ff     <= RHO_RST;
         dt_ff      <= DT_RST;
         start_x_ff <= START_RST;
         start_y_ff <= START_RST;
         start_z_ff <= START_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SIGMA:     sigma_ff   <= csr_wdata;
            CSR_BETA:      beta_ff    <= csr_wdata;
            CSR_RHO:       rho_ff     <= csr_wdata;
            CSR_TIME_STEP: dt_ff      <= csr_wdata;
            CSR_START_X:   start_x_ff <= csr_wdata;
            CSR_START_Y:   start_y_ff <= csr_wdata;
            CSR_START_Z:   start_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (op_ff)
         OP_DX:   begin mul_a = OPND_W'(sigma_ff); mul_b = OPND_W'(diff_yx_ff); end
         OP_DY:   begin mul_a = OPND_W'(pos_x_ff); mul_b = OPND_W'(diff_rz_ff); end
         OP_XY:   begin mul_a = OPND_W'(pos_x_ff); mul_b = OPND_W'(pos_y_ff);   end
         OP_DZ:   begin mul_a = OPND_W'(beta_ff);  mul_b = OPND_W'(pos_z_ff);   end
         OP_NX:   begin mul_a = {1'b0, dt_ff};     mul_b = OPND_W'(dx_ff);      end
         OP_NY:   begin mul_a = {1'b0, dt_ff};     mul_b = OPND_W'(dy_ff);      end
         OP_NZ:   begin mul_a = {1'b0, dt_ff};     mul_b = OPND_W'(dz_ff);      end
         default: begin mul_a = '0;                mul_b = '0;                  end
      endcase
   end

   assign post_op = op_type'(op_ff - 3'd1);
   assign prod_q  = mulq_post(prod_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      diff_yx_in   = diff_yx_ff;
      diff_rz_in   = diff_rz_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      m3_in        = m3_ff;
      dz_in        = dz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;

      unique case (state_ff)
         ST_IDLE: begin
            op_in = OP_DX;
            if (req_accept) begin
               if (req_restart) begin
                  pos_x_in = start_x_ff;
                  pos_y_in = start_y_ff;
                  pos_z_in = start_z_ff;
                  state_in = ST_DONE;
               end else begin
                  diff_yx_in = sat_sub(pos_y_ff, pos_x_ff);
                  diff_rz_in = sat_sub(rho_ff, pos_z_ff);
                  state_in   = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // post stage finishes the product registered for the previous slot
            case (post_op)
               OP_DX:   dx_in    = prod_q;
               OP_DY:   dy_in    = sat_sub(prod_q, pos_y_ff);
               OP_XY:   m3_in    = prod_q;
               OP_DZ:   dz_in    = sat_sub(m3_ff, prod_q);
               OP_NX:   pos_x_in = sat_add(pos_x_ff, prod_ff[2*DATA_W-1:DATA_W]);
               OP_NY:   pos_y_in = sat_add(pos_y_ff, prod_ff[2*DATA_W-1:DATA_W]);
               OP_NZ:   pos_z_in = sat_add(pos_z_ff, prod_ff[2*DATA_W-1:DATA_W]);
               default: ;
            endcase
            if (op_ff == OP_END) begin
               state_in = ST_DONE;
               op_in    = OP_DX;
            end else begin
               op_in = op_type'(op_ff + 3'd1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pos_x_ff;
               rsp_y_in     = pos_y_ff;
               rsp_z_in     = pos_z_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_DX;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= START_RST;
         pos_y_ff     <= START_RST;
         pos_z_ff     <= START_RST;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= pos_z_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= mul_a * mul_b;
      diff_yx_ff <= diff_yx_in;
      diff_rz_ff <= diff_rz_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      m3_ff      <= m3_in;
      dz_ff      <= dz_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
   end

   // a new result beat only comes out of the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside completion state");

   a_run_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && op_ff != OP_END) |=> (state_ff == ST_RUN && op_ff == $past(op_ff) + 3'd1))
      else $error("sequencer skipped a multiplier slot");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && op_ff == OP_END) |=> state_ff == ST_DONE)
      else $error("sequencer did not finish after last slot");

   a_restart_load: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_restart) |=> (pos_x_ff == $past(start_x_ff) &&
                                       pos_y_ff == $past(start_y_ff) &&
                                       pos_z_ff == $past(start_z_ff)))
      else $error("restart did not load start point");

   a_pos_stable_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !req_accept) |=> $stable(pos_x_ff) && $stable(pos_z_ff))
      else $error("position moved while idle");

endmodule

// File: verif/tb_lorenz_euler_integrator_unit.sv
// testbench for lorenz_euler_integrator_unit: random restart/step beats under stall,
// checked against a fixed-point lorenz euler predictor held in a scoreboard class
// depends on lei_pkg and the design top level
`timescale 1ns / 1ps

module tb_lorenz_euler_integrator_unit
   import lei_pkg::*;
;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_BEATS  = 89;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
   } point_type;

   class lorenz_point_tracker;
      logic signed [DATA_W-1:0] k_sigma, k_beta, k_rho;
      logic        [DATA_W-1:0] dt;
      logic signed [DATA_W-1:0] home_x, home_y, home_z;
      logic signed [DATA_W-1:0] pos_x, pos_y, pos_z;
      point_type                due_points[$];
      int                       errors;
      int                       points_checked;

      function new();
         k_sigma = SIGMA_RST;
         k_beta  = BETA_RST;
         k_rho   = RHO_RST;
         dt      = DT_RST;
         home_x  = START_RST;
         home_y  = START_RST;
         home_z  = START_RST;
         pos_x   = START_RST;
         pos_y   = START_RST;
         pos_z   = START_RST;
         errors  = 0;
         points_checked = 0;
      endfunction

      function logic signed [DATA_W-1:0] clamp_q(input longint v);
         if (v > longint'(Q_MAX)) return Q_MAX;
         if (v < longint'(Q_MIN)) return Q_MIN;
         return v[DATA_W-1:0];
      endfunction

      function logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                input logic signed [DATA_W-1:0] b);
         longint p;
         p = longint'(a) * longint'(b);
         return clamp_q(p >>> FRAC_BITS);
      endfunction

      function logic signed [DATA_W-1:0] euler_advance(input logic signed [DATA_W-1:0] old,
                                                       input logic signed [DATA_W-1:0] d);
         longint inc;
         inc = (longint'({32'h0, dt}) * longint'(d)) >>> 32;
         return clamp_q(longint'(old) + inc);
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
         case (idx)
            CSR_SIGMA:     k_sigma = data;
            CSR_BETA:      k_beta  = data;
            CSR_RHO:       k_rho   = data;
            CSR_TIME_STEP: dt      = data;
            CSR_START_X:   home_x  = data;
            CSR_START_Y:   home_y  = data;
            CSR_START_Z:   home_z  = data;
            default: ;
         endcase
      endfunction

      function void note_tick(input logic restart);
         logic signed [DATA_W-1:0] x, y, z, dx, dy, dz;
         point_type                p;
         if (restart) begin
            pos_x = home_x;
            pos_y = home_y;
            pos_z = home_z;
         end else begin
            x  = pos_x;
            y  = pos_y;
            z  = pos_z;
            dx = fx_mul(k_sigma, clamp_q(longint'(y) - longint'(x)));
            dy = clamp_q(longint'(fx_mul(x, clamp_q(longint'(k_rho) - longint'(z))))
                         - longint'(y));
            dz = clamp_q(longint'(fx_mul(x, y)) - longint'(fx_mul(k_beta, z)));
            pos_x = euler_advance(x, dx);
            pos_y = euler_advance(y, dy);
            pos_z = euler_advance(z, dz);
         end
         p.x = pos_x;
         p.y = pos_y;
         p.z = pos_z;
         due_points.push_back(p);
      endfunction

      function void report(input string field, input logic [DATA_W-1:0] want,
                           input logic [DATA_W-1:0] got);
         errors++;
         if (errors <= 10)
            $display("point %0d: %s expected %h, got %h", points_checked, field, want, got);
      endfunction

      function void check_point(input logic signed [DATA_W-1:0] x,
                                input logic signed [DATA_W-1:0] y,
                                input logic signed [DATA_W-1:0] z);
         point_type want;
         if (due_points.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("point %0d: unexpected beat %h %h %h", points_checked, x, y, z);
         end else begin
            want = due_points.pop_front();
            if (x !== want.x) report("x", want.x, x);
            if (y !== want.y) report("y", want.y, y);
            if (z !== want.z) report("z", want.z, z);
         end
         points_checked++;
      endfunction

      function int pending();
         return due_points.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_restart = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_point_x;
   logic signed [DATA_W-1:0] rsp_point_y;
   logic signed [DATA_W-1:0] rsp_point_z;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;

   lorenz_point_tracker tracker = new();
   bit steady = 1'b0;
   int cycle_count = 0;
   int ticks_sent = 0;
   int restarts_sent = 0;
   int csr_writes = 0;

   lorenz_euler_integrator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_restart(req_restart),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_point_x(rsp_point_x),
      .rsp_point_y(rsp_point_y),
      .rsp_point_z(rsp_point_z),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 16);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_point(rsp_point_x, rsp_point_y, rsp_point_z);
      end
   end

   task automatic send_tick(input logic restart);
      while (!steady && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_tick(restart);
      ticks_sent++;
      if (restart) restarts_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_reg(idx, data);
      csr_writes++;
   endtask

   // every register, then the unused index, which the block must ignore
   task automatic load_coefficients(input logic [DATA_W-1:0] sigma, beta, rho, step,
                                    input logic [DATA_W-1:0] sx, sy, sz);
      write_csr(CSR_SIGMA, sigma);
      write_csr(CSR_BETA, beta);
      write_csr(CSR_RHO, rho);
      write_csr(CSR_TIME_STEP, step);
      write_csr(CSR_START_X, sx);
      write_csr(CSR_START_Y, sy);
      write_csr(CSR_START_Z, sz);
      write_csr(CSR_SPARE, $urandom);
      csr_valid <= 1'b0;
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int  burst;
      logic restart;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // steps from the reset point, back-to-back restarts
      repeat (3) send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      drain();

      // saturating corner: extreme coefficients and largest step
      load_coefficients(Q_MAX, Q_MIN, Q_MAX, '1, Q_MAX, Q_MIN, Q_MAX);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      drain();

      // zero step; new start point held until restart
      load_coefficients(Q_MIN, Q_MAX, Q_MIN, '0, Q_MIN, Q_MAX, '0);
      send_tick(1'b0);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: load_coefficients(SIGMA_RST, BETA_RST, RHO_RST, DT_RST,
                                 START_RST, START_RST, START_RST);
            1: load_coefficients(Q_MAX, Q_MIN, Q_MAX, '1, Q_MAX, Q_MIN, Q_MAX);
            2: load_coefficients($urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
            3: load_coefficients($urandom_range(0, 32'h1400_0000),
                                 $urandom_range(0, 32'h0800_0000),
                                 $urandom_range(0, 32'h3000_0000),
                                 $urandom_range(32'h0010_0000, 32'h0400_0000),
                                 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000,
                                 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000,
                                 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
            4: load_coefficients(Q_MIN, Q_MAX, Q_MIN, 32'h8000_0000, Q_MIN, Q_MAX, Q_MIN);
            default: load_coefficients(SIGMA_RST, BETA_RST, RHO_RST, 32'd42949673,
                     32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000,
                     32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000,
                     32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
         endcase
         steady = (ph == 5);
         burst  = 0;
         // mostly long step runs, with occasional restart bursts as noise
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (burst == 0 && $urandom_range(99) < 3) burst = $urandom_range(2, 6);
            if (burst > 0) begin
               restart = 1'($urandom_range(1));
               burst--;
            end else begin
               restart = ($urandom_range(99) < 4);
            end
            if (n == 0) restart = 1'b1;
            send_tick(restart);
            if (n == PHASE_BEATS / 2) drain();
         end
         drain();
      end

      steady = 1'b0;
      repeat (20) @(posedge clock);
      $display("covered %0d ticks (%0d restarts) over 9 coefficient settings",
               ticks_sent, restarts_sent);
      $display("checked %0d points, %0d register writes, %0d bad fields",
               tracker.points_checked, csr_writes, tracker.errors);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/lei_pkg.sv
design/lorenz_euler_integrator_unit.sv
verif/tb_lorenz_euler_integrator_unit.sv
